### src/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent checks used by the heading controller.
`ifndef SYNTHESIS
`define HTRC_ASSERT_IMP(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!(rstn_s)) (ante) |-> (cons)) \
    else $error("htrc: same-cycle check failed");
`define HTRC_ASSERT_NXT(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!(rstn_s)) (ante) |=> (cons)) \
    else $error("htrc: next-cycle check failed");
`else
`define HTRC_ASSERT_IMP(lbl, clk_s, rstn_s, ante, cons)
`define HTRC_ASSERT_NXT(lbl, clk_s, rstn_s, ante, cons)
`endif

`endif

### src/htrc_pkg.sv
`timescale 1ns / 1ps

package htrc_pkg;

  localparam int RATE_FRAC_BITS_DEF = 12;

  localparam int ANGLE_W    = 16;
  localparam int TURN_W     = 17;   // 0..65536
  localparam int RATE_W     = 18;
  localparam int MAX_RATE_W = 17;
  localparam int CFG_IDX_W  = 2;
  localparam int PROD_W     = 48;
  localparam int TURN_SHIFT_BASE = 44;

  // 2*pi scaled by 2^28
  localparam logic [30:0] TWO_PI_Q28 = 31'd1686629713;

  localparam logic [ANGLE_W-1:0] PD_POS_LIMIT = 16'd24576;  // 3/8 turn
  localparam logic [ANGLE_W-1:0] PD_NEG_LIMIT = 16'd40960;  // 5/8 turn
  localparam logic [ANGLE_W-1:0] HALF_TURN    = 16'd32768;
  localparam logic [TURN_W-1:0]  FULL_TURN    = 17'h10000;

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_RATE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TOL_EN   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PD_MODE  = 2'd2;

  localparam logic [MAX_RATE_W-1:0] MAX_RATE_RST = 17'd4096;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_RND,
    ST_EVAL,
    ST_SQRT,
    ST_CLAMP,
    ST_SLEW,
    ST_FIN
  } htrc_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } sqrt_sts_t;

endpackage

### src/heading_turn_rate_controller_top.sv
`timescale 1ns / 1ps
// channel  | ports                                            | dir
// ---------+--------------------------------------------------+-----
// in       | in_valid/in_ready, target_angle, heading, rate   | in
// out      | out_valid/out_ready, out_drive_rate              | out
// cfg      | cfg_we, cfg_index, cfg_wdata                     | in
//
// PD mode: accept, then the MUL, RND, EVAL and FIN states. Bang-bang mode: accept, MUL,
// RND, EVAL, the square-root unit at one root bit per cycle, then CLAMP, SLEW, FIN.
// One item in flight; in_ready is high only while idle. A finished result waits
// in the output register, and the next item may be accepted meanwhile.
// rst_n is synchronous: config returns to defaults, previous error clears.

`include "assert_macros.svh"

module heading_turn_rate_controller_top #(
  parameter int RATE_FRAC_BITS = htrc_pkg::RATE_FRAC_BITS_DEF
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     in_valid,
  output logic                                     in_ready,
  input  logic [htrc_pkg::ANGLE_W-1:0]             in_target_angle,
  input  logic [htrc_pkg::ANGLE_W-1:0]             in_heading,
  input  logic signed [htrc_pkg::RATE_W-1:0]       in_measured_rate,
  output logic                                     out_valid,
  input  logic                                     out_ready,
  output logic signed [htrc_pkg::RATE_W-1:0]       out_drive_rate,
  input  logic                                     cfg_we,
  input  logic [htrc_pkg::CFG_IDX_W-1:0]           cfg_index,
  input  logic [htrc_pkg::MAX_RATE_W-1:0]          cfg_wdata
);

  localparam int F      = RATE_FRAC_BITS;
  localparam int RW     = htrc_pkg::RATE_W;
  localparam int EW     = F + 3;            // error in Q.F, below 1.25*pi
  localparam int SHIFT  = htrc_pkg::TURN_SHIFT_BASE - F;
  localparam int XW     = 2 * F + 7;        // 15 * e * 2^F
  localparam int MW     = (XW + 1) / 2;
  localparam int CW     = ((MW > RW) ? MW : RW) + 2;
  localparam int DW     = CW + 5;
  localparam int TW     = EW + 7;
  localparam int AMW    = RW + 7;
  localparam int MG     = (EW + 3 > htrc_pkg::MAX_RATE_W) ? EW + 3 : htrc_pkg::MAX_RATE_W;
  localparam int PW     = htrc_pkg::PROD_W;

  localparam logic [PW-1:0]         ROUND_C   = PW'(64'd1 << (SHIFT - 1));
  localparam logic [TW-1:0]         THR_030   = TW'(3 << F);
  localparam logic [TW-1:0]         THR_012   = TW'(12 << F);
  localparam logic [AMW-1:0]        THR_RATE  = AMW'(1 << F);
  localparam logic signed [DW-1:0]  SLEW_THR  = DW'(12 << F);
  localparam logic signed [CW-1:0]  DELTA_C   = CW'((12 * (1 << F) + 5) / 10);
  localparam logic signed [CW-1:0]  OUT_MAX_C = CW'(131071);
  localparam logic signed [CW-1:0]  OUT_MIN_C = CW'(-131072);

  htrc_pkg::htrc_state_t state_r, state_nxt;

  logic [htrc_pkg::MAX_RATE_W-1:0] max_rate_r;
  logic                            tol_en_r;
  logic                            pd_mode_r;

  logic [htrc_pkg::TURN_W-1:0] a_r, a_nxt;
  logic                        neg_r, neg_nxt;
  logic signed [RW-1:0]        meas_r, meas_nxt;
  logic [PW-1:0]               prod_r, prod_nxt;
  logic [EW-1:0]               e_r, e_nxt;
  logic [EW-1:0]               prev_err_r, prev_err_nxt;
  logic signed [CW-1:0]        cmd_r, cmd_nxt;
  logic signed [RW-1:0]        out_drive_rate_r, out_drive_rate_nxt;
  logic                        out_valid_r, out_valid_nxt;

  logic                        sqrt_start;
  logic [XW-1:0]               sqrt_x;
  logic [MW-1:0]               sqrt_root;
  htrc_pkg::sqrt_sts_t         sqrt_sts;

  // ---- accept-side decode
  logic [htrc_pkg::ANGLE_W-1:0] d_in;
  logic                         pd_pos;
  logic                         neg_in;

  assign d_in   = in_target_angle - in_heading;
  assign pd_pos = (d_in <= htrc_pkg::PD_POS_LIMIT) ||
                  ((d_in < htrc_pkg::PD_NEG_LIMIT) && !in_measured_rate[RW-1]);
  assign neg_in = pd_mode_r ? !pd_pos : (d_in >= htrc_pkg::HALF_TURN);

  // ---- dead band
  logic [RW-1:0]  ameas;
  logic [AMW-1:0] ameas_x, ameas100;
  logic [TW-1:0]  e_x, e10, e100;
  logic           dead;
  logic [EW-1:0]  e_z;
  logic [EW+3:0]  e15;

  assign ameas    = meas_r[RW-1] ? $unsigned(-meas_r) : $unsigned(meas_r);
  assign ameas_x  = AMW'(ameas);
  assign ameas100 = (ameas_x << 6) + (ameas_x << 5) + (ameas_x << 2);
  assign e_x      = TW'(e_r);
  assign e10      = (e_x << 3) + (e_x << 1);
  assign e100     = (e_x << 6) + (e_x << 5) + (e_x << 2);
  assign dead     = tol_en_r &&
                    ((e10 < THR_030) || ((e100 < THR_012) && (ameas100 < THR_RATE)));
  assign e_z      = dead ? '0 : e_r;
  assign e15      = {e_z, 4'b0000} - {4'b0000, e_z};
  assign sqrt_x   = {e15, {F{1'b0}}};

  // ---- PD magnitude: |7e - 4e_prev| / 2, limited to max_rate
  logic [EW+2:0]        e7;
  logic signed [EW+3:0] w2, w2_abs;
  logic [MG-1:0]        mag_x, max_x, mag_lim;
  logic signed [CW-1:0] pd_cmd, max_cmd, bb_cmd;

  assign e7      = {e_r, 3'b000} - {3'b000, e_r};
  assign w2      = $signed({1'b0, e7}) - $signed({2'b00, prev_err_r, 2'b00});
  assign w2_abs  = w2[EW+3] ? -w2 : w2;
  assign mag_x   = MG'(w2_abs[EW+3:1]);
  assign max_x   = MG'(max_rate_r);
  assign mag_lim = (mag_x > max_x) ? max_x : mag_x;
  assign pd_cmd  = neg_r ? -$signed(CW'(mag_lim)) : $signed(CW'(mag_lim));
  assign max_cmd = $signed(CW'(max_rate_r));
  assign bb_cmd  = (e_z == '0) ? '0 : (neg_r ? -max_cmd : max_cmd);

  // ---- clamp and slew
  logic signed [CW-1:0] m_pos, cmd_clamp;
  logic signed [CW-1:0] acmd, lo_lim, hi_lim, cmd_slew;
  logic signed [DW-1:0] diff, diff10;

  assign m_pos     = $signed(CW'(sqrt_root));
  assign cmd_clamp = (cmd_r < -m_pos) ? -m_pos : ((cmd_r > m_pos) ? m_pos : cmd_r);
  assign acmd      = cmd_r[CW-1] ? -cmd_r : cmd_r;
  assign diff      = DW'(acmd) - DW'(meas_r);
  assign diff10    = (diff <<< 3) + (diff <<< 1);
  assign lo_lim    = CW'(meas_r) - DELTA_C;
  assign hi_lim    = CW'(meas_r) + DELTA_C;
  always_comb begin
    cmd_slew = cmd_r;
    if (diff10 > SLEW_THR) begin
      if (cmd_r < lo_lim) begin
        cmd_slew = lo_lim;
      end else if (cmd_r > hi_lim) begin
        cmd_slew = hi_lim;
      end
    end
  end

  logic signed [RW-1:0] cmd_sat;
  assign cmd_sat = (cmd_r > OUT_MAX_C) ? RW'(OUT_MAX_C) :
                   ((cmd_r < OUT_MIN_C) ? RW'(OUT_MIN_C) : RW'(cmd_r));

  htrc_isqrt #(
    .XW(XW)
  ) u_isqrt (
    .clk  (clk),
    .rst_n(rst_n),
    .start(sqrt_start),
    .x    (sqrt_x),
    .root (sqrt_root),
    .sts  (sqrt_sts)
  );

  // ---- sequencer
  always_comb begin
    state_nxt          = state_r;
    a_nxt              = a_r;
    neg_nxt            = neg_r;
    meas_nxt           = meas_r;
    prod_nxt           = prod_r;
    e_nxt              = e_r;
    prev_err_nxt       = prev_err_r;
    cmd_nxt            = cmd_r;
    out_drive_rate_nxt = out_drive_rate_r;
    out_valid_nxt      = out_valid_r && !out_ready;
    sqrt_start         = 1'b0;
    case (state_r)
      htrc_pkg::ST_IDLE: begin
        if (in_valid) begin
          neg_nxt   = neg_in;
          a_nxt     = neg_in ? htrc_pkg::FULL_TURN - {1'b0, d_in} : {1'b0, d_in};
          meas_nxt  = in_measured_rate;
          state_nxt = htrc_pkg::ST_MUL;
        end
      end
      htrc_pkg::ST_MUL: begin
        prod_nxt  = PW'(a_r) * PW'(htrc_pkg::TWO_PI_Q28);
        state_nxt = htrc_pkg::ST_RND;
      end
      htrc_pkg::ST_RND: begin
        e_nxt     = EW'((prod_r + ROUND_C) >> SHIFT);
        state_nxt = htrc_pkg::ST_EVAL;
      end
      htrc_pkg::ST_EVAL: begin
        if (pd_mode_r) begin
          cmd_nxt      = pd_cmd;
          prev_err_nxt = e_r;
          state_nxt    = htrc_pkg::ST_FIN;
        end else begin
          cmd_nxt    = bb_cmd;
          sqrt_start = 1'b1;
          state_nxt  = htrc_pkg::ST_SQRT;
        end
      end
      htrc_pkg::ST_SQRT: begin
        if (sqrt_sts.done) begin
          state_nxt = htrc_pkg::ST_CLAMP;
        end
      end
      htrc_pkg::ST_CLAMP: begin
        cmd_nxt   = cmd_clamp;
        state_nxt = htrc_pkg::ST_SLEW;
      end
      htrc_pkg::ST_SLEW: begin
        cmd_nxt   = cmd_slew;
        state_nxt = htrc_pkg::ST_FIN;
      end
      htrc_pkg::ST_FIN: begin
        // hold here until the output register frees up
        if (!out_valid_r || out_ready) begin
          out_drive_rate_nxt = cmd_sat;
          out_valid_nxt      = 1'b1;
          state_nxt          = htrc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = htrc_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= htrc_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      prev_err_r  <= '0;
      max_rate_r  <= htrc_pkg::MAX_RATE_RST;
      tol_en_r    <= 1'b0;
      pd_mode_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      prev_err_r  <= prev_err_nxt;
      if (cfg_we) begin
        if (cfg_index == htrc_pkg::CFG_MAX_RATE) begin
          max_rate_r <= cfg_wdata;
        end
        if (cfg_index == htrc_pkg::CFG_TOL_EN) begin
          tol_en_r <= cfg_wdata[0];
        end
        if (cfg_index == htrc_pkg::CFG_PD_MODE) begin
          pd_mode_r <= cfg_wdata[0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    a_r              <= a_nxt;
    neg_r            <= neg_nxt;
    meas_r           <= meas_nxt;
    prod_r           <= prod_nxt;
    e_r              <= e_nxt;
    cmd_r            <= cmd_nxt;
    out_drive_rate_r <= out_drive_rate_nxt;
  end

  assign in_ready       = (state_r == htrc_pkg::ST_IDLE);
  assign out_valid      = out_valid_r;
  assign out_drive_rate = out_drive_rate_r;

  `HTRC_ASSERT_NXT(a_accept_starts, clk, rst_n, in_valid && in_ready, state_r == htrc_pkg::ST_MUL)
  `HTRC_ASSERT_IMP(a_sqrt_done_in_wait, clk, rst_n, sqrt_sts.done, state_r == htrc_pkg::ST_SQRT)
  `HTRC_ASSERT_NXT(a_prev_err_hold, clk, rst_n, state_r != htrc_pkg::ST_EVAL, $stable(prev_err_r))

endmodule

### src/htrc_isqrt.sv
`timescale 1ns / 1ps

// Digit-by-digit integer square root, two radicand bits per cycle.
module htrc_isqrt #(
  parameter int XW = 31
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic [XW-1:0]           x,
  output logic [(XW+1)/2-1:0]     root,
  output htrc_pkg::sqrt_sts_t     sts
);

  localparam int N     = (XW + 1) / 2;
  localparam int CNT_W = $clog2(N + 1);

  logic [2*N-1:0] xs_r, xs_nxt;
  logic [N+1:0]   rem_r, rem_nxt;
  logic [N-1:0]   root_r, root_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic           busy_r, busy_nxt;
  logic           done_r, done_nxt;

  logic [N+1:0]   shifted;
  logic [N+1:0]   trial;
  logic           ge;

  assign shifted = {rem_r[N-1:0], xs_r[2*N-1 -: 2]};
  assign trial   = {root_r, 2'b01};
  assign ge      = shifted >= trial;

  always_comb begin
    xs_nxt   = xs_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      xs_nxt   = (2*N)'(x);
      rem_nxt  = '0;
      root_nxt = '0;
      cnt_nxt  = CNT_W'(N);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      xs_nxt   = {xs_r[2*N-3:0], 2'b00};
      rem_nxt  = ge ? shifted - trial : shifted;
      root_nxt = {root_r[N-2:0], ge};
      cnt_nxt  = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    xs_r   <= xs_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
  end

  assign root     = root_r;
  assign sts.busy = busy_r;
  assign sts.done = done_r;

endmodule

### verif/heading_turn_rate_controller_top_tb.sv
`timescale 1ns / 1ps

module heading_turn_rate_controller_top_tb;

  localparam int FRAC       = htrc_pkg::RATE_FRAC_BITS_DEF;
  localparam int CYCLE_LIMIT = 400000;
  localparam int RAND_PER_SETTING = 22;

  typedef struct packed {
    logic [htrc_pkg::ANGLE_W-1:0]       target;
    logic [htrc_pkg::ANGLE_W-1:0]       heading;
    logic signed [htrc_pkg::RATE_W-1:0] rate;
  } tick_item_t;

  logic                                clk;
  logic                                rst_n;
  logic                                in_valid;
  logic                                in_ready;
  logic [htrc_pkg::ANGLE_W-1:0]        in_target_angle;
  logic [htrc_pkg::ANGLE_W-1:0]        in_heading;
  logic signed [htrc_pkg::RATE_W-1:0]  in_measured_rate;
  logic                                out_valid;
  logic                                out_ready;
  logic signed [htrc_pkg::RATE_W-1:0]  out_drive_rate;
  logic                                cfg_we;
  logic [htrc_pkg::CFG_IDX_W-1:0]      cfg_index;
  logic [htrc_pkg::MAX_RATE_W-1:0]     cfg_wdata;

  // controller copy used for prediction
  logic [htrc_pkg::MAX_RATE_W-1:0]     cur_max_rate;
  logic                                cur_tol_en;
  logic                                cur_pd_mode;
  longint                              pd_last_err;

  logic signed [htrc_pkg::RATE_W-1:0]  drive_rate_q[$];
  int                                  err_cnt;
  int                                  ticks_sent;
  int                                  rates_checked;
  int                                  pd_ticks;
  int                                  bb_ticks;
  int                                  cycle_cnt;
  int                                  send_idle_pct;
  int                                  recv_stall_pct;
  int                                  hold_len;
  int                                  hold_req;
  int                                  hold_ack;
  int                                  hold_left;

  heading_turn_rate_controller_top u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_target_angle  (in_target_angle),
    .in_heading       (in_heading),
    .in_measured_rate (in_measured_rate),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_drive_rate   (out_drive_rate),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // angle in turn units (0..65536) to radians, unsigned Q.F, half step up
  function automatic longint angle_to_rad(longint unsigned a);
    longint unsigned sh;
    sh = htrc_pkg::TURN_SHIFT_BASE - FRAC;
    return longint'((a * 64'(htrc_pkg::TWO_PI_Q28) + (64'd1 << (sh - 1))) >> sh);
  endfunction

  function automatic longint root_floor(longint unsigned x);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return longint'(r);
  endfunction

  function automatic logic signed [htrc_pkg::RATE_W-1:0] predict_drive_rate(tick_item_t t);
    logic [htrc_pkg::ANGLE_W-1:0] d;
    longint             one;
    longint             meas;
    longint             e;
    longint             cmd;
    longint             m;
    longint             acmd;
    longint             amag;
    longint             w2;
    longint             step;
    logic               neg;
    logic               pos_dir;
    d    = t.target - t.heading;
    one  = longint'(1) << FRAC;
    meas = longint'(t.rate);
    if (cur_pd_mode) begin
      if (d <= htrc_pkg::PD_POS_LIMIT) pos_dir = 1'b1;
      else if (d >= htrc_pkg::PD_NEG_LIMIT) pos_dir = 1'b0;
      else pos_dir = (meas >= 0);
      e = pos_dir ? angle_to_rad(d) : angle_to_rad(htrc_pkg::FULL_TURN - d);
      w2 = 7 * e - 4 * pd_last_err;
      amag = (w2 < 0 ? -w2 : w2) >>> 1;
      if (amag > longint'(cur_max_rate)) amag = longint'(cur_max_rate);
      cmd = pos_dir ? amag : -amag;
      pd_last_err = e;
    end else begin
      neg = (d >= htrc_pkg::HALF_TURN);
      e = angle_to_rad(neg ? htrc_pkg::FULL_TURN - d : d);
      if (cur_tol_en) begin
        if (e * 10 < 3 * one) e = 0;
        if (e * 100 < 12 * one && (meas < 0 ? -meas : meas) * 100 < one) e = 0;
      end
      if (e == 0) cmd = 0;
      else cmd = neg ? -longint'(cur_max_rate) : longint'(cur_max_rate);
      m = root_floor(e * 15 * one);
      if (cmd < -m) cmd = -m;
      if (cmd > m) cmd = m;
      // slew test uses the command magnitude, not its sign
      acmd = cmd < 0 ? -cmd : cmd;
      if ((acmd - meas) * 10 > 12 * one) begin
        step = (12 * one + 5) / 10;
        if (cmd < meas - step) cmd = meas - step;
        if (cmd > meas + step) cmd = meas + step;
      end
    end
    if (cmd > 131071) cmd = 131071;
    if (cmd < -131072) cmd = -131072;
    return cmd[htrc_pkg::RATE_W-1:0];
  endfunction

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d results outstanding", $time, drive_rate_q.size());
      $display("simulation failed");
      $finish;
    end
  end

  // receiver: random stalls plus an occasional long hold-off
  always @(posedge clk) begin
    if (hold_req != hold_ack) begin
      hold_ack = hold_req;
      hold_left = hold_len;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    logic signed [htrc_pkg::RATE_W-1:0] want;
    if (rst_n && out_valid && out_ready) begin
      rates_checked = rates_checked + 1;
      if (drive_rate_q.size() == 0) begin
        $display("%0t: unexpected drive_rate item, actual %0d", $time, out_drive_rate);
        err_cnt = err_cnt + 1;
      end else begin
        want = drive_rate_q.pop_front();
        if (out_drive_rate !== want) begin
          $display("%0t: drive_rate mismatch, expected %0d actual %0d",
                   $time, want, out_drive_rate);
          err_cnt = err_cnt + 1;
        end
      end
    end
  end

  task automatic send_tick(tick_item_t t);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_target_angle  <= t.target;
    in_heading       <= t.heading;
    in_measured_rate <= t.rate;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    drive_rate_q.push_back(predict_drive_rate(t));
    ticks_sent = ticks_sent + 1;
    if (cur_pd_mode) pd_ticks = pd_ticks + 1;
    else bb_ticks = bb_ticks + 1;
  endtask

  task automatic send_err(logic [htrc_pkg::ANGLE_W-1:0] d,
                          logic signed [htrc_pkg::RATE_W-1:0] rate);
    tick_item_t t;
    t.target  = htrc_pkg::ANGLE_W'($urandom);
    t.heading = t.target - d;
    t.rate    = rate;
    send_tick(t);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (drive_rate_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_config(logic [htrc_pkg::MAX_RATE_W-1:0] mr, logic tol, logic pd);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_index <= htrc_pkg::CFG_MAX_RATE;
    cfg_wdata <= mr;
    @(posedge clk);
    cfg_index <= htrc_pkg::CFG_TOL_EN;
    cfg_wdata <= htrc_pkg::MAX_RATE_W'(tol);
    @(posedge clk);
    cfg_index <= htrc_pkg::CFG_PD_MODE;
    cfg_wdata <= htrc_pkg::MAX_RATE_W'(pd);
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_max_rate = mr;
    cur_tol_en   = tol;
    cur_pd_mode  = pd;
  endtask

  // mostly errors near decision bounds; rates small, moderate or fully random
  function automatic tick_item_t rand_tick();
    tick_item_t t;
    logic [htrc_pkg::ANGLE_W-1:0] d;
    int pick;
    pick = $urandom_range(5);
    case (pick)
      0: d = htrc_pkg::ANGLE_W'($urandom_range(40) - 20);
      1: d = htrc_pkg::HALF_TURN + htrc_pkg::ANGLE_W'($urandom_range(40) - 20);
      2: d = htrc_pkg::PD_POS_LIMIT + htrc_pkg::ANGLE_W'($urandom_range(40) - 20);
      3: d = htrc_pkg::PD_NEG_LIMIT + htrc_pkg::ANGLE_W'($urandom_range(40) - 20);
      4: d = ($urandom_range(1) ? 16'd3128 : 16'd62408) +
             htrc_pkg::ANGLE_W'($urandom_range(8) - 4);
      default: d = htrc_pkg::ANGLE_W'($urandom);
    endcase
    t.target  = htrc_pkg::ANGLE_W'($urandom);
    t.heading = t.target - d;
    pick = $urandom_range(3);
    case (pick)
      0: t.rate = htrc_pkg::RATE_W'($urandom_range(128) - 64);
      1: t.rate = htrc_pkg::RATE_W'($urandom_range(20000) - 10000);
      default: t.rate = htrc_pkg::RATE_W'($urandom);
    endcase
    return t;
  endfunction

  task automatic test_bang_bang_limits();
    tick_item_t t;
    set_config(htrc_pkg::MAX_RATE_RST, 1'b0, 1'b0);
    t = '{target: 16'hFFFF, heading: 16'h0000, rate: 18'sd0};
    send_tick(t);
    t = '{target: 16'h0000, heading: 16'hFFFF, rate: 18'sd131071};
    send_tick(t);
    send_err(16'd0, 18'sd0);
    send_err(htrc_pkg::HALF_TURN, 18'sd0);       // half turn counts as -pi
    send_err(16'd16384, -18'sd131072);
    send_err(16'd49152, 18'sd131071);
    send_err(16'd1, 18'sd5000);
    send_err(16'd65535, -18'sd5000);
  endtask

  task automatic test_dead_band();
    set_config(htrc_pkg::MAX_RATE_RST, 1'b1, 1'b0);
    send_err(16'd3128, 18'sd0);                  // just under 0.3 rad
    send_err(16'd3129, 18'sd0);
    send_err(16'd62408, 18'sd100);
    send_err(16'd1251, 18'sd40);                 // under 0.12 with slow rate
    send_err(16'd1252, -18'sd41);
    send_err(htrc_pkg::HALF_TURN, -18'sd40);
  endtask

  task automatic test_pd_sectors();
    set_config(17'h1FFFF, 1'b0, 1'b1);
    send_err(htrc_pkg::PD_POS_LIMIT, 18'sd0);
    send_err(htrc_pkg::PD_POS_LIMIT + 16'd1, 18'sd0);  // middle sector, zero rate is positive
    send_err(htrc_pkg::PD_POS_LIMIT + 16'd1, -18'sd1);
    send_err(htrc_pkg::PD_NEG_LIMIT - 16'd1, 18'sd7);
    send_err(htrc_pkg::PD_NEG_LIMIT, 18'sd0);
    send_err(16'd0, 18'sd0);
    send_err(16'd65535, -18'sd131072);
    set_config(17'd0, 1'b0, 1'b1);
    send_err(16'd8000, 18'sd0);
  endtask

  task automatic test_random_flow();
    int ph;
    int k;
    int n;
    logic [htrc_pkg::MAX_RATE_W-1:0] mr;
    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 78; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 78; end
        default: begin send_idle_pct = 26; recv_stall_pct = 26; end
      endcase
      for (k = 0; k < 6; k++) begin
        case (k)
          0: set_config(htrc_pkg::MAX_RATE_RST, 1'b0, 1'b0);
          1: set_config(htrc_pkg::MAX_RATE_RST, 1'b1, 1'b0);
          2: set_config(17'h1FFFF, 1'b1, 1'b0);
          3: set_config(17'd0, 1'b0, 1'b0);
          4: set_config(htrc_pkg::MAX_RATE_W'($urandom_range(20000)), 1'b0, 1'b1);
          default: begin
            mr = htrc_pkg::MAX_RATE_W'($urandom);
            set_config(mr, 1'($urandom), 1'($urandom));
          end
        endcase
        for (n = 0; n < RAND_PER_SETTING; n++) send_tick(rand_tick());
      end
    end
  endtask

  task automatic test_backpressure();
    int n;
    set_config(htrc_pkg::MAX_RATE_RST, 1'b0, 1'b1);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_len = 300;
    hold_req = hold_req + 1;
    // block holds one result and one in flight, then input stalls
    for (n = 0; n < 6; n++) send_tick(rand_tick());
  endtask

  task automatic test_drain_pause();
    int n;
    send_idle_pct  = 26;
    recv_stall_pct = 26;
    for (n = 0; n < 5; n++) send_tick(rand_tick());
    in_valid <= 1'b0;
    while (drive_rate_q.size() != 0) @(posedge clk);
    for (n = 0; n < 5; n++) send_tick(rand_tick());
  endtask

  initial begin
    rst_n            <= 1'b0;
    in_valid         <= 1'b0;
    in_target_angle  <= '0;
    in_heading       <= '0;
    in_measured_rate <= '0;
    out_ready        <= 1'b0;
    cfg_we           <= 1'b0;
    cfg_index        <= htrc_pkg::CFG_MAX_RATE;
    cfg_wdata        <= '0;
    cur_max_rate   = htrc_pkg::MAX_RATE_RST;
    cur_tol_en     = 1'b0;
    cur_pd_mode    = 1'b0;
    pd_last_err    = 0;
    err_cnt        = 0;
    ticks_sent     = 0;
    rates_checked  = 0;
    pd_ticks       = 0;
    bb_ticks       = 0;
    cycle_cnt      = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_len       = 0;
    hold_req       = 0;
    hold_ack       = 0;
    hold_left      = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_bang_bang_limits();
    test_dead_band();
    test_pd_sectors();
    test_random_flow();
    test_backpressure();
    test_drain_pause();

    wait_idle();
    repeat (30) @(posedge clk);
    if (drive_rate_q.size() != 0) begin
      $display("%0t: %0d expected drive_rate items never arrived", $time, drive_rate_q.size());
      err_cnt = err_cnt + 1;
    end
    $display("covered %0d ticks (%0d bang-bang, %0d PD), %0d commands checked, %0d errors",
             ticks_sent, bb_ticks, pd_ticks, rates_checked, err_cnt);
    $display("flow: free run, sender gaps, receiver stalls, mixed, long hold-off, drain pause");
    if (err_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
